// ===== src/bbc_pkg.sv =====
// Shared types, constants and conversion helpers for the binary / BCD converter.
package bbc_pkg;

    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned BCD_DIGITS     = 20;
    localparam int unsigned BCD_W          = 4 * BCD_DIGITS;
    localparam int unsigned BITS_PER_STAGE = 8;
    localparam int unsigned NUM_STAGES     = VALUE_W / BITS_PER_STAGE;
    // Input register, conversion stages and output register.
    localparam int unsigned LATENCY        = NUM_STAGES + 2;

    localparam logic CMD_BIN2BCD = 1'b0;
    localparam logic CMD_BCD2BIN = 1'b1;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [3:0] MAX_DIGIT = 4'd9;

    typedef struct packed {
        logic                  cmd;
        logic [1:0]            size_sel;
        logic [VALUE_W-1:0]    value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    result;
        logic                  overflow;
        logic                  bad_digit;
    } resp_t;

    // Work word that travels down the pipeline.
    typedef struct packed {
        logic                  cmd;
        logic [1:0]            size_sel;
        logic [VALUE_W-1:0]    src;
        logic [BCD_W-1:0]      acc;
        logic                  bad;
    } stage_t;

    function automatic logic [VALUE_W-1:0] width_mask(input logic [1:0] sel);
        logic [VALUE_W-1:0] m;
        unique case (sel)
            SIZE_8:  m = {{(VALUE_W-8){1'b0}},  {8{1'b1}}};
            SIZE_16: m = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
            SIZE_32: m = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
            default: m = {VALUE_W{1'b1}};
        endcase
        return m;
    endfunction

    // One double dabble step: correct every digit of five or more, then shift a bit in.
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] acc,
                                                    input logic bit_in);
        logic [BCD_W-1:0] a;
        a = acc;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (a[4*d +: 4] >= 4'd5) begin
                a[4*d +: 4] = a[4*d +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    // Two Horner steps in decimal: acc * 100 + hi * 10 + lo.
    function automatic logic [VALUE_W-1:0] horner2(input logic [VALUE_W-1:0] acc,
                                                   input logic [3:0] hi,
                                                   input logic [3:0] lo);
        logic [VALUE_W-1:0] scaled;
        logic [7:0]         pair;
        scaled = acc * 64'd100;
        pair   = 8'({4'd0, hi} * 8'd10) + {4'd0, lo};
        return scaled + {{(VALUE_W-8){1'b0}}, pair};
    endfunction

endpackage

// ===== src/bbc_stage.sv =====
// One conversion stage: eight double dabble steps or two decimal digits of Horner.
module bbc_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  bbc_pkg::stage_t data_in,
    output logic            valid_out,
    output bbc_pkg::stage_t data_out
);
    import bbc_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        logic [BCD_W-1:0] acc_v;
        logic [3:0]       hi;
        logic [3:0]       lo;
        data_next = data_in;
        acc_v     = data_in.acc;
        hi        = data_in.src[VALUE_W-1 -: 4];
        lo        = data_in.src[VALUE_W-5 -: 4];
        if (data_in.cmd == CMD_BIN2BCD)
        begin
            for (int i = 0; i < BITS_PER_STAGE; i++) begin
                acc_v = dabble_bit(acc_v, data_in.src[VALUE_W-1-i]);
            end
        end
        else
        begin
            acc_v = {{(BCD_W-VALUE_W){1'b0}}, horner2(acc_v[VALUE_W-1:0], hi, lo)};
            data_next.bad = data_in.bad | (hi > MAX_DIGIT) | (lo > MAX_DIGIT);
        end
        data_next.acc = acc_v;
        data_next.src = data_in.src << BITS_PER_STAGE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== src/bbc_format.sv =====
// Output stage: width masking, overflow and bad digit flags, result register.
module bbc_format (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  bbc_pkg::stage_t data_in,
    output logic            done,
    output bbc_pkg::resp_t  resp
);
    import bbc_pkg::*;

    logic  done_reg;
    resp_t resp_reg;
    resp_t resp_next;
    logic  high_digits;

    always_comb
    begin
        unique case (data_in.size_sel)
            SIZE_8:  high_digits = |data_in.acc[BCD_W-1:8];
            SIZE_16: high_digits = |data_in.acc[BCD_W-1:16];
            SIZE_32: high_digits = |data_in.acc[BCD_W-1:32];
            default: high_digits = |data_in.acc[BCD_W-1:64];
        endcase
        resp_next.result = data_in.acc[VALUE_W-1:0] & width_mask(data_in.size_sel);
        if (data_in.cmd == CMD_BIN2BCD)
        begin
            resp_next.overflow  = high_digits;
            resp_next.bad_digit = 1'b0;
        end
        else
        begin
            resp_next.overflow  = 1'b0;
            resp_next.bad_digit = data_in.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
    end

    assign done = done_reg;
    assign resp = resp_reg;

endmodule

// ===== src/binary_bcd_converter_unit.sv =====
// Top level of the pipelined binary / packed BCD converter.
//
//  Channel   Handshake             Payload          Direction
//  -------   -------------------   --------------   ---------
//  request   start, busy           request (req_t)  in
//  result    done (one cycle)      resp (resp_t)    out
//
// A request is taken at every rising edge where start is high and busy is low,
// and its result appears on resp with done high once it has passed the pipe.
// The latency is one input register, eight conversion stages (eight double
// dabble bit steps or two decimal Horner digits each) and one output register.
// A new request can be taken in every cycle while busy is low, so the sustained rate is one per clock.
// Busy is high while reset is asserted and is cleared by the clock once reset is released.
// The receiver cannot stall, so results never wait and nothing is dropped.
module binary_bcd_converter_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bbc_pkg::req_t  request,
    output logic           done,
    output bbc_pkg::resp_t resp
);
    import bbc_pkg::*;

    logic   busy_reg;
    logic   busy_next;
    logic   in_valid_reg;
    stage_t in_data_reg;
    stage_t in_data_next;

    logic   stage_valid [NUM_STAGES+1];
    stage_t stage_data  [NUM_STAGES+1];

    assign busy_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            in_valid_reg <= start & ~busy_reg;
        end
    end

    // The source word is masked to the selected width; leading zeros are
    // harmless to both conversions, so every width runs the same eight stages.
    always_comb
    begin
        in_data_next.cmd      = request.cmd;
        in_data_next.size_sel = request.size_sel;
        in_data_next.src      = request.value & width_mask(request.size_sel);
        in_data_next.acc      = '0;
        in_data_next.bad      = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    assign busy           = busy_reg;
    assign stage_valid[0] = in_valid_reg;
    assign stage_data[0]  = in_data_reg;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        bbc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[s]),
            .data_in   (stage_data[s]),
            .valid_out (stage_valid[s+1]),
            .data_out  (stage_data[s+1])
        );
    end

    bbc_format u_format (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (stage_valid[NUM_STAGES]),
        .data_in  (stage_data[NUM_STAGES]),
        .done     (done),
        .resp     (resp)
    );

endmodule

// ===== src/bbc_checker.sv =====
// Port-level assertions for the converter and the bind that attaches them.
module bbc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input bbc_pkg::req_t  request,
    input logic           done,
    input bbc_pkg::resp_t resp
);
    import bbc_pkg::*;

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching request");

    a_request_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not produce a result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(resp.overflow && resp.bad_digit))
        else $error("overflow and bad digit raised together");

    a_bad_digit_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (done && resp.bad_digit) |-> ($past(request.cmd, LATENCY) == CMD_BCD2BIN))
        else $error("bad digit flagged on a binary to BCD request");

    a_byte_width: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(request.size_sel, LATENCY) == SIZE_8))
            |-> (resp.result[VALUE_W-1:8] == '0))
        else $error("byte-wide result has bits above its width");

endmodule

bind binary_bcd_converter_unit bbc_checker u_bbc_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the binary / packed BCD converter.
`timescale 1ns / 1ps

module tb_top;

    import bbc_pkg::*;

    // The run stops with a failure when this many cycles pass with no accepted request
    // and no result. The longest honest gap is a burst of idles plus the pipe latency.
    localparam int unsigned STALL_LIMIT    = 4000;
    localparam int unsigned RANDOM_ITEMS   = 1130;
    // Items in this range of the drive count are presented with no idle cycles at all.
    localparam int unsigned BURST_FIRST    = 500;
    localparam int unsigned BURST_LAST     = 800;
    localparam int unsigned IDLE_PERCENT   = 23;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    req_t  request = '0;
    logic  busy;
    logic  done;
    resp_t resp;

    // Requests waiting to be driven, and the conversions that the pipe still owes us.
    req_t        pending_requests[$];
    resp_t       expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    int unsigned drive_count    = 0;
    // Set at each rising edge when the request on the port was taken by the block.
    logic        req_taken      = 1'b0;

    binary_bcd_converter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .resp    (resp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Mask of the bits that belong to the selected word width.
    function automatic logic [VALUE_W-1:0] size_mask(input logic [1:0] sel);
        logic [VALUE_W-1:0] m;
        case (sel)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Ten to the power of the digit count of the width: the first value that overflows.
    function automatic logic [VALUE_W-1:0] decimal_span(input logic [1:0] sel);
        logic [VALUE_W-1:0] p;
        int unsigned        digits;
        p      = 64'd1;
        digits = 2 << sel;
        for (int unsigned i = 0; i < digits; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Fills the bits above the selected width with noise; the block must ignore them.
    function automatic logic [VALUE_W-1:0] with_junk(input logic [1:0] sel,
                                                     input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] m;
        m = size_mask(sel);
        return (v & m) | (random_word() & ~m);
    endfunction

    // Expected result of one request. Binary to BCD peels off decimal digits from the
    // bottom and flags whatever is left over; BCD to binary weights each nibble by its
    // power of ten, raw values above nine included, and flags such nibbles.
    function automatic resp_t predict_conversion(input req_t rq);
        resp_t              r;
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] n;
        logic [VALUE_W-1:0] weight;
        logic [VALUE_W-1:0] nib;
        int unsigned        digits;
        r      = '0;
        m      = size_mask(rq.size_sel);
        v      = rq.value & m;
        digits = 2 << rq.size_sel;
        if (rq.cmd == CMD_BIN2BCD)
        begin
            n = v;
            for (int unsigned i = 0; i < digits; i++)
            begin
                r.result = r.result | ((n % 64'd10) << (4 * i));
                n        = n / 64'd10;
            end
            r.overflow = (n != 64'd0);
        end
        else
        begin
            weight = 64'd1;
            for (int unsigned i = 0; i < digits; i++)
            begin
                nib = (v >> (4 * i)) & 64'h0F;
                if (nib > 64'd9)
                begin
                    r.bad_digit = 1'b1;
                end
                r.result = r.result + nib * weight;
                weight   = weight * 64'd10;
            end
        end
        r.result = r.result & m;
        return r;
    endfunction

    task automatic queue_request(input logic cmd, input logic [1:0] sel,
                                 input logic [VALUE_W-1:0] v);
        req_t rq;
        rq.cmd      = cmd;
        rq.size_sel = sel;
        rq.value    = v;
        pending_requests.push_back(rq);
    endtask

    // A packed BCD word of random valid digits over the whole 64 bits.
    function automatic logic [VALUE_W-1:0] random_bcd();
        logic [VALUE_W-1:0] w;
        w = '0;
        for (int unsigned i = 0; i < 16; i++)
        begin
            w[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return w;
    endfunction

    // Driver. A request stays on the port until the monitor saw it taken; only then is
    // the next one presented, or start dropped for an idle cycle. Every signal gets at
    // most one assignment per falling edge, so a back-to-back request keeps start high.
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (pending_requests.size() != 0 &&
                ((drive_count >= BURST_FIRST && drive_count <= BURST_LAST) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                request     <= pending_requests.pop_front();
                start       <= 1'b1;
                drive_count <= drive_count + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. Results are compared first, then a request taken at this edge adds its
    // prediction; with the pipe latency the two can never refer to the same request.
    always @(posedge clk)
    begin
        resp_t want;
        req_taken <= start && !busy;
        if (done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none outstanding: expected none, actual %h %b %b",
                         $time, resp.result, resp.overflow, resp.bad_digit);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (resp.result !== want.result)
                begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, want.result, resp.result);
                    mismatch_count = mismatch_count + 1;
                end
                if (resp.overflow !== want.overflow)
                begin
                    $display("%0t: overflow mismatch: expected %b, actual %b",
                             $time, want.overflow, resp.overflow);
                    mismatch_count = mismatch_count + 1;
                end
                if (resp.bad_digit !== want.bad_digit)
                begin
                    $display("%0t: bad_digit mismatch: expected %b, actual %b",
                             $time, want.bad_digit, resp.bad_digit);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
        if (start && !busy)
        begin
            expected_results.push_back(predict_conversion(request));
        end
        if (done || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [1:0]         sel;
        logic               cmd;
        logic [VALUE_W-1:0] span;
        logic [VALUE_W-1:0] v;
        int unsigned        mode;
        int unsigned        pos;

        // Directed part. For each width: zero, the largest value that fits in decimal,
        // the first value that overflows, the all-ones word, a word of nines and a word
        // of invalid nibbles. Bits above the width carry noise, but in the all-ones words.
        for (int unsigned s = 0; s < 4; s++)
        begin
            sel  = 2'(s);
            span = decimal_span(sel);
            queue_request(CMD_BIN2BCD, sel, with_junk(sel, 64'd0));
            queue_request(CMD_BIN2BCD, sel, with_junk(sel, span - 64'd1));
            queue_request(CMD_BIN2BCD, sel, with_junk(sel, span));
            queue_request(CMD_BIN2BCD, sel, 64'hFFFF_FFFF_FFFF_FFFF);
            queue_request(CMD_BCD2BIN, sel, with_junk(sel, 64'h9999_9999_9999_9999));
            queue_request(CMD_BCD2BIN, sel, 64'hFFFF_FFFF_FFFF_FFFF);
        end

        // Random part. Most requests are in range (digits that fit, valid BCD), the rest
        // overflow, sit on the decimal boundary, carry one invalid nibble or are random words.
        for (int unsigned k = 0; k < RANDOM_ITEMS; k++)
        begin
            sel  = 2'($urandom_range(0, 3));
            cmd  = $urandom_range(0, 1) ? CMD_BCD2BIN : CMD_BIN2BCD;
            span = decimal_span(sel);
            mode = $urandom_range(0, 9);
            if (cmd == CMD_BIN2BCD)
            begin
                if (mode <= 5)
                begin
                    v = random_word() % span;
                end
                else if (mode <= 7)
                begin
                    v = random_word();
                end
                else if (mode == 8)
                begin
                    v = span - 64'd2 + 64'($urandom_range(0, 3));
                end
                else
                begin
                    v = size_mask(sel) - 64'($urandom_range(0, 3));
                end
            end
            else
            begin
                v = random_bcd();
                if (mode >= 7)
                begin
                    pos           = $urandom_range(0, (2 << sel) - 1);
                    v[4*pos +: 4] = 4'($urandom_range(10, 15));
                end
                else if (mode == 6)
                begin
                    v = random_word();
                end
            end
            queue_request(cmd, sel, with_junk(sel, v));
        end

        // Reset is applied once and released on a falling edge, away from the sampling.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every request was taken and every result came back, then let the
        // pipe run empty to catch any stray result.
        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
